FILE: rtl/fpcs_pkg.sv
// ----------------------------------------------------------------------------
// fpcs_pkg
// Shared types, codes and sizes of the flash program command sequencer.
// ----------------------------------------------------------------------------
package fpcs_pkg;

   // Page and erase block sizes. The erase block size is a power of two.
   localparam int PAGE_BYTES        = 256;
   localparam int ERASE_BLOCK_BYTES = 65536;
   localparam int ADDRESS_BITS      = 24;

   localparam int RX_W          = 8;
   localparam int ACTION_W      = 4;
   localparam int FLASH_ADDR_W  = 24;
   localparam int LENGTH_W      = 32;
   localparam int MAX_RESULTS   = 4;
   localparam int COUNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int INDEX_W       = $clog2(MAX_RESULTS);

   // The byte counter holds a page offset in write mode and a length byte
   // index (0 to 3) in length mode.
   localparam int PAGE_CNT_W = ($clog2(PAGE_BYTES) > 2) ? $clog2(PAGE_BYTES) : 2;
   localparam int BLOCK_W    = ($clog2(ERASE_BLOCK_BYTES) < ADDRESS_BITS) ?
                               $clog2(ERASE_BLOCK_BYTES) : ADDRESS_BITS;

   // Command characters accepted in the ready mode.
   localparam logic [RX_W-1:0] CMD_BOOT    = 8'h45;  // E
   localparam logic [RX_W-1:0] CMD_TAKE    = 8'h74;  // t
   localparam logic [RX_W-1:0] CMD_RELEASE = 8'h54;  // T
   localparam logic [RX_W-1:0] CMD_ID      = 8'h69;  // i
   localparam logic [RX_W-1:0] CMD_ERASE   = 8'h65;  // e
   localparam logic [RX_W-1:0] CMD_READ0   = 8'h72;  // r
   localparam logic [RX_W-1:0] CMD_WRITE   = 8'h77;  // w

   typedef enum logic [ACTION_W-1:0] {
      ACT_BOOT        = 4'd0,
      ACT_TAKE        = 4'd1,
      ACT_RELEASE     = 4'd2,
      ACT_ID          = 4'd3,
      ACT_ERASE_CHIP  = 4'd4,
      ACT_READ0       = 4'd5,
      ACT_ERASE_BLOCK = 4'd6,
      ACT_START_PAGE  = 4'd7,
      ACT_DATA        = 4'd8,
      ACT_END_PAGE    = 4'd9,
      ACT_WAIT        = 4'd10
   } action_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_LENGTH = 3'b010,
      MODE_DATA   = 3'b100
   } mode_type;

   typedef struct packed {
      action_type              action;
      logic [FLASH_ADDR_W-1:0] flash_address;
      logic [RX_W-1:0]         data_byte;
   } result_type;

   // All actions caused by one received byte.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] entry;
      logic [COUNT_W-1:0]           count;
   } bundle_type;

endpackage

FILE: rtl/fpcs_decoder.sv
// ----------------------------------------------------------------------------
// fpcs_decoder
// Sequencer state and the single-pass decode of one received byte into a
// bundle of flash actions.
// ----------------------------------------------------------------------------
module fpcs_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [fpcs_pkg::RX_W-1:0] rx_byte,
   output fpcs_pkg::bundle_type      bundle
);
   import fpcs_pkg::*;

   mode_type                mode_ff, mode_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [LENGTH_W-1:0]     rem_ff, rem_in;
   logic [PAGE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PAGE_CNT_W:0]     cnt_next;

   function automatic result_type make_result(action_type act,
                                              logic [ADDRESS_BITS-1:0] addr,
                                              logic [RX_W-1:0] data);
      result_type r;
      r.action        = act;
      r.flash_address = FLASH_ADDR_W'(addr);
      r.data_byte     = data;
      return r;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      cnt_next = {1'b0, cnt_ff} + (PAGE_CNT_W + 1)'(1);
      bundle   = '0;
      case (mode_ff)
         MODE_LENGTH: begin
            // Length arrives least significant byte first.
            case (cnt_ff[1:0])
               2'd0:    rem_in[7:0]   = rx_byte;
               2'd1:    rem_in[15:8]  = rx_byte;
               2'd2:    rem_in[23:16] = rx_byte;
               default: rem_in[31:24] = rx_byte;
            endcase
            cnt_in      = '0;
            cnt_in[1:0] = cnt_ff[1:0] + 2'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               mode_in = MODE_DATA;
               bundle.entry[bundle.count[INDEX_W-1:0]] =
                  make_result(ACT_ERASE_BLOCK, addr_ff, '0);
               bundle.count = bundle.count + COUNT_W'(1);
            end
         end
         MODE_DATA: begin
            if (cnt_ff == '0) begin
               bundle.entry[bundle.count[INDEX_W-1:0]] =
                  make_result(ACT_START_PAGE, addr_ff, '0);
               bundle.count = bundle.count + COUNT_W'(1);
            end
            bundle.entry[bundle.count[INDEX_W-1:0]] = make_result(ACT_DATA, '0, rx_byte);
            bundle.count = bundle.count + COUNT_W'(1);
            if (cnt_next >= (PAGE_CNT_W + 1)'(PAGE_BYTES)) begin
               cnt_in  = '0;
               addr_in = addr_ff + ADDRESS_BITS'(PAGE_BYTES);
               bundle.entry[bundle.count[INDEX_W-1:0]] = make_result(ACT_END_PAGE, '0, '0);
               bundle.count = bundle.count + COUNT_W'(1);
               if (rem_ff <= LENGTH_W'(PAGE_BYTES)) begin
                  // Length used up: the write ends after this page.
                  rem_in  = '0;
                  mode_in = MODE_IDLE;
                  bundle.entry[bundle.count[INDEX_W-1:0]] = make_result(ACT_WAIT, '0, '0);
                  bundle.count = bundle.count + COUNT_W'(1);
               end else begin
                  rem_in = rem_ff - LENGTH_W'(PAGE_BYTES);
                  if (addr_in[BLOCK_W-1:0] == '0) begin
                     bundle.entry[bundle.count[INDEX_W-1:0]] =
                        make_result(ACT_WAIT, '0, '0);
                     bundle.count = bundle.count + COUNT_W'(1);
                     bundle.entry[bundle.count[INDEX_W-1:0]] =
                        make_result(ACT_ERASE_BLOCK, addr_in, '0);
                     bundle.count = bundle.count + COUNT_W'(1);
                  end
               end
            end else begin
               cnt_in = cnt_next[PAGE_CNT_W-1:0];
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            case (rx_byte)
               CMD_BOOT: begin
                  bundle.entry[0] = make_result(ACT_BOOT, '0, '0);
                  bundle.count    = COUNT_W'(1);
               end
               CMD_TAKE: begin
                  bundle.entry[0] = make_result(ACT_TAKE, '0, '0);
                  bundle.count    = COUNT_W'(1);
               end
               CMD_RELEASE: begin
                  bundle.entry[0] = make_result(ACT_RELEASE, '0, '0);
                  bundle.count    = COUNT_W'(1);
               end
               CMD_ID: begin
                  bundle.entry[0] = make_result(ACT_ID, '0, '0);
                  bundle.count    = COUNT_W'(1);
               end
               CMD_ERASE: begin
                  bundle.entry[0] = make_result(ACT_ERASE_CHIP, '0, '0);
                  bundle.count    = COUNT_W'(1);
               end
               CMD_READ0: begin
                  bundle.entry[0] = make_result(ACT_READ0, '0, '0);
                  bundle.count    = COUNT_W'(1);
               end
               CMD_WRITE: begin
                  mode_in = MODE_LENGTH;
                  addr_in = '0;
                  cnt_in  = '0;
               end
               default: begin
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         addr_ff <= '0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         addr_ff <= addr_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

FILE: rtl/fpcs_emitter.sv
// ----------------------------------------------------------------------------
// fpcs_emitter
// Result register that holds one bundle of actions and hands them out one
// transaction at a time.
// ----------------------------------------------------------------------------
module fpcs_emitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  fpcs_pkg::bundle_type              bundle,
   output logic                              free,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fpcs_pkg::ACTION_W-1:0]     rsp_action,
   output logic [fpcs_pkg::FLASH_ADDR_W-1:0] rsp_flash_address,
   output logic [fpcs_pkg::RX_W-1:0]         rsp_data_byte,
   output logic                              rsp_last
);
   import fpcs_pkg::*;

   bundle_type         bundle_ff;
   logic               busy_ff;
   logic [INDEX_W-1:0] idx_ff;
   result_type         current;

   assign current           = bundle_ff.entry[idx_ff];
   assign rsp_valid         = busy_ff;
   assign rsp_action        = current.action;
   assign rsp_flash_address = current.flash_address;
   assign rsp_data_byte     = current.data_byte;
   assign rsp_last          = ({1'b0, idx_ff} == COUNT_W'(bundle_ff.count - COUNT_W'(1)));

   // A new bundle may enter in the cycle that the last action of the old one leaves.
   assign free = !busy_ff || (rsp_ready && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load && bundle.count != '0) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (rsp_last) begin
            busy_ff <= 1'b0;
         end
         idx_ff <= idx_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load && bundle.count != '0) begin
         bundle_ff <= bundle;
      end
   end

endmodule

FILE: rtl/flash_program_command_sequencer.sv
// ----------------------------------------------------------------------------
// flash_program_command_sequencer
// Turns received bytes into a stream of serial-flash actions.
// ----------------------------------------------------------------------------
// Each req_ transaction carries one received byte. In the ready mode it is a
// single-letter command; after 'w' four length bytes follow, least
// significant first, and then the data bytes of the write. Each byte causes
// zero to four actions, which leave on the rsp_ channel one transaction per
// cycle while rsp_ready is high, with rsp_last set on the final action of
// that byte. The first action of a byte is valid in the cycle after the
// byte is accepted. A byte causing at most one action can follow in every
// cycle while rsp_ready is high; a byte causing more actions holds the
// single result register until its last action is accepted, and the next
// byte is taken in that cycle. A byte with no action leaves the register free.
// When the receiver stalls, the pending action holds on rsp_ and req_ready
// drops once the result register cannot be freed in that cycle.
// Reset returns the sequencer to the ready mode with zero address, length
// and byte count, and drops any actions not yet delivered.
// ----------------------------------------------------------------------------
module flash_program_command_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fpcs_pkg::RX_W-1:0]         req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fpcs_pkg::ACTION_W-1:0]     rsp_action,
   output logic [fpcs_pkg::FLASH_ADDR_W-1:0] rsp_flash_address,
   output logic [fpcs_pkg::RX_W-1:0]         rsp_data_byte,
   output logic                              rsp_last
);
   import fpcs_pkg::*;

   bundle_type bundle;
   logic       free;
   logic       accept;

   assign req_ready = free;
   assign accept    = req_valid && free;

   fpcs_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .bundle  (bundle)
   );

   fpcs_emitter u_emitter (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .bundle            (bundle),
      .free              (free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_flash_address (rsp_flash_address),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last          (rsp_last)
   );

endmodule
